// File: rtl/voxel_dag_point_lookup_macros.svh
// Assertion macros for the voxel DAG point lookup block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef VOXEL_DAG_POINT_LOOKUP_MACROS_SVH
`define VOXEL_DAG_POINT_LOOKUP_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define VDAG_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define VDAG_ASSERT(name, prop, msg) \
  `VDAG_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/vdag_pkg.sv
// Shared types and constants of the voxel DAG point lookup block.
// No dependencies; used by the node memory and the top level.
package vdag_pkg;

  // One node memory word: a child mask or an absolute child pointer.
  typedef logic [31:0] word_t;

  // Meaning of an input item, carried in tuser.
  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CENTER_X    = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y    = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z    = 3'd2;
  localparam logic [2:0] CFG_ROOT_SIDE   = 3'd3;
  localparam logic [2:0] CFG_TREE_LEVELS = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [30:0] ROOT_SIDE_RESET   = 31'd65536;
  localparam logic [4:0]  TREE_LEVELS_RESET = 5'd16;

  // Only the low byte of a mask word holds child bits.
  localparam logic [7:0] CHILD_MASK_BITS = 8'hFF;

  // Number of set bits in a byte.
  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + 4'(v[k]);
    end
    return n;
  endfunction

endpackage

// File: rtl/vdag_node_mem.sv
// Node memory of the voxel DAG lookup: one write port, one read port, registered read data.
// Depends on vdag_pkg for the word type.
module vdag_node_mem #(
  parameter int Depth = 65536
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [$clog2(Depth)-1:0]  wr_addr_i,
  input  vdag_pkg::word_t           wr_data_i,
  input  logic                      rd_en_i,
  input  logic [$clog2(Depth)-1:0]  rd_addr_i,
  output vdag_pkg::word_t           rd_data_o
);

  vdag_pkg::word_t mem_q [Depth];
  vdag_pkg::word_t rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: rtl/voxel_dag_point_lookup.sv
// Top level of the voxel DAG point lookup: configuration, walk sequencer and shared adder.
// Depends on vdag_pkg, vdag_node_mem and voxel_dag_point_lookup_macros.svh.
//
// Channel   Direction  Handshake                       Content
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o  memory write or lookup item
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i  lookup result item
// cfg       in         cfg_valid_i/cfg_ready_o          register index and data
//
// A write item goes straight to node memory. A lookup walks each level in order: one mask read,
// three compares, one pointer read, three centre moves, all on one 34-bit adder and the single
// memory read port. Shallow and too deep lookups end without a walk. Input is not ready while a
// lookup runs or waits for the output register. The result register is freed when the result
// item is taken. Reset clears control state and sets configuration to its reset values; node memory
// contents stay undefined until written. NODE_WORDS must be a power of two; the block does not check it.
`include "voxel_dag_point_lookup_macros.svh"

module voxel_dag_point_lookup #(
  parameter int NODE_WORDS = 65536,
  parameter int MAX_LEVELS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Lookup and write items.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // write_address[15:0], write_word[47:16], point_x[79:48], point_y[111:80],
  // point_z[143:112], depth[148:144], zero[151:149]
  input  logic [151:0] s_axis_tdata_i,
  // command[0]
  input  logic [0:0]   s_axis_tuser_i,
  // Result items.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // found[0], node_index[16:1], stop_level[21:17], depth_error[22], zero[23]
  output logic [23:0]  m_axis_tdata_o,
  // Configuration writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int AddrW = $clog2(NODE_WORDS);
  localparam logic [31:0] AddrMask = 32'(NODE_WORDS - 1);
  localparam logic [4:0]  MaxLevels = 5'(MAX_LEVELS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MASK,
    S_CMP,
    S_TEST,
    S_MOVE,
    S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic signed [31:0] cfg_cx_q, cfg_cy_q, cfg_cz_q;
  logic [30:0]        root_side_q;
  logic [4:0]         tree_levels_q;

  // Walk state.
  logic signed [33:0] c_q [3];
  logic signed [33:0] p_q [3];
  logic [30:0]        hs_q;
  logic [2:0]         g_q;
  logic [1:0]         axis_q;
  logic [4:0]         lvl_q;
  logic [4:0]         depth_q;
  logic [AddrW-1:0]   idx_q;

  // Pending result and output register.
  logic        res_found_q, res_derr_q;
  logic [15:0] res_node_q;
  logic [4:0]  res_stop_q;
  logic        m_valid_q;
  logic [23:0] m_data_q;

  // Input item fields.
  logic [15:0] in_waddr;
  logic [31:0] in_wword, in_px, in_py, in_pz;
  logic [4:0]  in_depth;
  vdag_pkg::cmd_e in_cmd;
  logic        s_accept;

  assign in_waddr = s_axis_tdata_i[15:0];
  assign in_wword = s_axis_tdata_i[47:16];
  assign in_px    = s_axis_tdata_i[79:48];
  assign in_py    = s_axis_tdata_i[111:80];
  assign in_pz    = s_axis_tdata_i[143:112];
  assign in_depth = s_axis_tdata_i[148:144];
  assign in_cmd   = vdag_pkg::cmd_e'(s_axis_tuser_i[0]);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Effective level count, limited to one up to the maximum.
  logic [4:0] levels;
  always_comb begin
    if (tree_levels_q == 5'd0) begin
      levels = 5'd1;
    end else if (tree_levels_q > MaxLevels) begin
      levels = MaxLevels;
    end else begin
      levels = tree_levels_q;
    end
  end

  // Node memory and its address selection.
  vdag_pkg::word_t  mem_rd;
  logic [31:0]      wr_addr_mod;
  logic [31:0]      ptr_mod;
  logic [2:0]       oct;
  logic             child_bit;
  logic [AddrW-1:0] slot_addr;
  logic [AddrW-1:0] rd_addr;
  logic             rd_en;
  logic             wr_en;

  assign wr_addr_mod = {16'd0, in_waddr} & AddrMask;
  assign ptr_mod     = mem_rd & AddrMask;
  assign oct         = g_q;
  assign child_bit   = mem_rd[oct];
  assign slot_addr   = idx_q +
      AddrW'(vdag_pkg::ones8((mem_rd[7:0] & vdag_pkg::CHILD_MASK_BITS) >> oct));
  assign wr_en       = s_accept && (in_cmd == vdag_pkg::CMD_WRITE);
  assign rd_en       = (state_q == S_MASK) || ((state_q == S_TEST) && child_bit);
  assign rd_addr     = (state_q == S_MASK) ? idx_q : slot_addr;

  vdag_node_mem #(
    .Depth(NODE_WORDS)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr_mod[AddrW-1:0]),
    .wr_data_i(in_wword),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(mem_rd)
  );

  // Shared adder: compares point with centre (c - p) or moves the centre by the half side.
  logic signed [33:0] alu_a, alu_b, alu_sum;
  logic               alu_sub;
  logic               cur_g;

  assign cur_g = g_q[2'd2 - axis_q];

  always_comb begin
    alu_a = c_q[axis_q];
    if (state_q == S_CMP) begin
      alu_b   = p_q[axis_q];
      alu_sub = 1'b1;
    end else begin
      alu_b   = {3'b000, hs_q};
      alu_sub = !cur_g;
    end
    alu_sum = alu_a + (alu_b ^ {34{alu_sub}}) + 34'(alu_sub);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cx_q      <= '0;
      cfg_cy_q      <= '0;
      cfg_cz_q      <= '0;
      root_side_q   <= vdag_pkg::ROOT_SIDE_RESET;
      tree_levels_q <= vdag_pkg::TREE_LEVELS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        vdag_pkg::CFG_CENTER_X:    cfg_cx_q      <= cfg_data_i;
        vdag_pkg::CFG_CENTER_Y:    cfg_cy_q      <= cfg_data_i;
        vdag_pkg::CFG_CENTER_Z:    cfg_cz_q      <= cfg_data_i;
        vdag_pkg::CFG_ROOT_SIDE:   root_side_q   <= cfg_data_i[30:0];
        vdag_pkg::CFG_TREE_LEVELS: tree_levels_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Walk sequencer, result staging and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      axis_q      <= 2'd0;
      g_q         <= '0;
      lvl_q       <= '0;
      depth_q     <= '0;
      idx_q       <= '0;
      hs_q        <= '0;
      c_q         <= '{default: '0};
      p_q         <= '{default: '0};
      res_found_q <= 1'b0;
      res_node_q  <= '0;
      res_stop_q  <= '0;
      res_derr_q  <= 1'b0;
    end else begin
      // The output register empties when its item is taken, unless a new result refills it.
      if (m_valid_q && m_axis_tready_i && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_accept && (in_cmd == vdag_pkg::CMD_LOOKUP)) begin
            res_found_q <= 1'b0;
            res_node_q  <= 16'd0;
            res_stop_q  <= 5'd0;
            res_derr_q  <= 1'b0;
            depth_q     <= in_depth;
            p_q[0]      <= 34'(signed'(in_px));
            p_q[1]      <= 34'(signed'(in_py));
            p_q[2]      <= 34'(signed'(in_pz));
            c_q[0]      <= 34'(cfg_cx_q);
            c_q[1]      <= 34'(cfg_cy_q);
            c_q[2]      <= 34'(cfg_cz_q);
            hs_q        <= root_side_q >> 2;
            idx_q       <= '0;
            lvl_q       <= 5'd0;
            axis_q      <= 2'd0;
            if (in_depth > levels) begin
              res_derr_q <= 1'b1;
              state_q    <= S_DONE;
            end else if (in_depth < 5'd2) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_MASK;
            end
          end
        end
        S_MASK: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          // Strictly greater point selects the upper half: c - p is negative.
          g_q[2'd2 - axis_q] <= alu_sum[33];
          if (axis_q == 2'd2) begin
            axis_q  <= 2'd0;
            state_q <= S_TEST;
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        S_TEST: begin
          if (child_bit) begin
            state_q <= S_MOVE;
          end else begin
            res_stop_q <= lvl_q;
            state_q    <= S_DONE;
          end
        end
        S_MOVE: begin
          c_q[axis_q] <= alu_sum;
          if (axis_q == 2'd2) begin
            axis_q <= 2'd0;
            idx_q  <= ptr_mod[AddrW-1:0];
            if ((lvl_q + 5'd2) == depth_q) begin
              res_found_q <= 1'b1;
              res_node_q  <= ptr_mod[15:0];
              res_stop_q  <= depth_q - 5'd1;
              state_q     <= S_DONE;
            end else begin
              lvl_q   <= lvl_q + 5'd1;
              hs_q    <= hs_q >> 1;
              state_q <= S_MASK;
            end
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {1'b0, res_derr_q, res_stop_q, res_node_q, res_found_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // The walk is under way in any of these states.
  logic walking;
  assign walking = (state_q == S_MASK) || (state_q == S_CMP) || (state_q == S_TEST) ||
                   (state_q == S_MOVE);

  // A result item appears only when a finished lookup is handed over.
  `VDAG_ASSERT(a_result_from_done, $rose(m_valid_q) |-> $past(state_q == S_DONE), "stray result")
  // The walk never goes beyond the level before the target depth.
  `VDAG_ASSERT(a_level_bound, walking |-> (6'(lvl_q) + 6'd2 <= 6'(depth_q)), "walk too deep")
  // A found node and a depth error exclude each other.
  `VDAG_ASSERT(a_found_no_derr, m_valid_q |-> !(m_data_q[0] && m_data_q[22]), "found and error")
  // A result that is not found carries node index zero.
  `VDAG_ASSERT(a_missing_node_zero, m_valid_q && !m_data_q[0] |-> !(|m_data_q[16:1]), "stray index")

endmodule
